// ----- sv/entity_update_packet_deframer_defines.svh -----
// Assertion helpers shared by the deframer modules.
// Each expects clk and rst_n in scope.
`ifndef ENTITY_UPDATE_PACKET_DEFRAMER_DEFINES_SVH
`define ENTITY_UPDATE_PACKET_DEFRAMER_DEFINES_SVH

`define EUPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define EUPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/eupd_pkg.sv -----
package eupd_pkg;

    localparam int SLOT_COUNT_DEF = 4096;
    localparam int DATA_BYTES_DEF = 256;

    localparam int LIMIT_W = 13;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    // result queue
    localparam int RES_PER_ITEM = 3;
    localparam int RES_DEPTH    = 8;
    localparam int PTR_W        = $clog2(RES_DEPTH);
    localparam int CNT_W        = $clog2(RES_DEPTH + 1);
    localparam int RES_CNT_W    = $clog2(RES_PER_ITEM + 1);

    // packet layout
    localparam logic [1:0] COUNT_LAST = 2'd3;
    localparam logic [2:0] ID_LAST    = 3'd2;
    localparam logic [2:0] HDR_LAST   = 3'd7;

    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_ACTIVE = 1'b1;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_SIZE  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic REG_ENTITY_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_HDR,
        PH_DATA,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] entity_slot;
        logic [7:0]  byte_offset;
        logic [7:0]  data_value;
        logic [8:0]  record_size;
        logic        packet_ok;
        logic        last;
    } res_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_val;
    } slot_ctl_t;

endpackage

// ----- sv/eupd_pkt_if.sv -----
interface eupd_pkt_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  packet_byte;
    logic        first_byte;
    logic [15:0] packet_length;
    logic [11:0] slot_index;
    logic        active_value;

    modport source (
        output valid, command, packet_byte, first_byte, packet_length, slot_index,
               active_value,
        input  ready
    );

    modport sink (
        input  valid, command, packet_byte, first_byte, packet_length, slot_index,
               active_value,
        output ready
    );
endinterface

// ----- sv/eupd_res_if.sv -----
interface eupd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] entity_slot;
    logic [7:0]  byte_offset;
    logic [7:0]  data_value;
    logic [8:0]  record_size;
    logic        packet_ok;
    logic        last;

    modport source (
        output valid, kind, entity_slot, byte_offset, data_value, record_size,
               packet_ok, last,
        input  ready
    );

    modport sink (
        input  valid, kind, entity_slot, byte_offset, data_value, record_size,
               packet_ok, last,
        output ready
    );
endinterface

// ----- sv/eupd_slot_mem.sv -----
module eupd_slot_mem #(
    parameter int SLOT_COUNT = eupd_pkg::SLOT_COUNT_DEF,
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  eupd_pkg::slot_ctl_t ctl,
    input  logic [AW-1:0]       raddr,
    input  logic [AW-1:0]       waddr,
    output logic                rdata,
    output logic                busy
);
    import eupd_pkg::*;

    logic          mem [SLOT_COUNT];
    logic          rdata_reg;
    logic          busy_reg;
    logic          busy_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;

    // clearing sweep after reset
    always_comb
    begin
        busy_next    = busy_reg;
        clr_cnt_next = clr_cnt_reg;
        if (busy_reg)
        begin
            if (clr_cnt_reg == AW'(SLOT_COUNT - 1))
                busy_next = 1'b0;
            else
                clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[clr_cnt_reg] <= 1'b0;
        else if (ctl.wr_en)
            mem[waddr] <= ctl.wr_val;
        if (ctl.rd_en)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

// ----- sv/eupd_res_fifo.sv -----
`include "entity_update_packet_deframer_defines.svh"

module eupd_res_fifo (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic [eupd_pkg::RES_CNT_W-1:0]                      push_n,
    input  eupd_pkg::res_t [eupd_pkg::RES_PER_ITEM-1:0]         bundle,
    output logic                                                space_ok,
    eupd_res_if.source                                          res
);
    import eupd_pkg::*;

    res_t             entries_reg [RES_DEPTH];
    res_t             head;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign pop      = res.valid && res.ready;
    assign space_ok = count_reg <= CNT_W'(RES_DEPTH - RES_PER_ITEM);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_PER_ITEM; i++)
        begin
            if (RES_CNT_W'(i) < push_n)
                entries_reg[PTR_W'(wr_ptr_reg + PTR_W'(i))] <= bundle[i];
        end
    end

    assign head            = entries_reg[rd_ptr_reg];
    assign res.valid       = count_reg != '0;
    assign res.kind        = head.kind;
    assign res.entity_slot = head.entity_slot;
    assign res.byte_offset = head.byte_offset;
    assign res.data_value  = head.data_value;
    assign res.record_size = head.record_size;
    assign res.packet_ok   = head.packet_ok;
    assign res.last        = head.last;

    `EUPD_ASSERT_IMP(a_no_overflow, push_n != '0, (count_reg + push_n) <= RES_DEPTH,
        "result queue overflow")
    `EUPD_ASSERT_NXT(a_pop_count, pop && (push_n == '0), count_reg == $past(count_reg) - 1'b1,
        "result count not decremented on pop")

endmodule

// ----- sv/eupd_parser.sv -----
`include "entity_update_packet_deframer_defines.svh"

module eupd_parser #(
    parameter int SLOT_COUNT = eupd_pkg::SLOT_COUNT_DEF,
    parameter int DATA_BYTES = eupd_pkg::DATA_BYTES_DEF,
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    eupd_pkt_if.sink                                    pkt,
    input  logic [eupd_pkg::LIMIT_W-1:0]                entity_limit,
    input  logic                                        busy,
    input  logic                                        space_ok,
    output eupd_pkg::slot_ctl_t                         mem_ctl,
    output logic [AW-1:0]                               mem_raddr,
    output logic [AW-1:0]                               mem_waddr,
    input  logic                                        mem_rdata,
    output logic [eupd_pkg::RES_CNT_W-1:0]              push_n,
    output eupd_pkg::res_t [eupd_pkg::RES_PER_ITEM-1:0] bundle
);
    import eupd_pkg::*;

    phase_t        phase_reg, phase_next;
    logic [15:0]   pos_reg, pos_next;
    logic [31:0]   total_reg, total_next;
    logic [31:0]   seen_reg, seen_next;
    logic [55:0]   hdr_reg, hdr_next;
    logic [2:0]    hcnt_reg, hcnt_next;
    logic [11:0]   slot_reg, slot_next;
    logic [8:0]    size_reg, size_next;
    logic [15:0]   rem_reg, rem_next;
    logic [7:0]    off_reg, off_next;
    logic          we_reg, we_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [23:0]   lat_slot_reg, lat_slot_next;
    logic          act_reg, act_next;

    logic          is_byte;
    logic          is_set;
    phase_t        phase_cur;
    logic [15:0]   pos_cur;
    logic [2:0]    hcnt_cur;
    logic [31:0]   seen_cur;
    logic          we_cur;
    logic [16:0]   pos_inc;
    logic          last_byte;
    logic          hdr_stop;
    logic [31:0]   rec_size;
    logic [23:0]   rec_slot;
    logic [23:0]   rd_slot;
    logic          fits;
    logic          size_zero;
    logic          acc_rec;
    logic          data_end;
    logic          id_read;
    logic [AW+11:0] sidx_ext;
    logic          a_v, b_v, c_v;
    res_t          res_a, res_b, res_c;

    assign pkt.ready = !busy && space_ok;
    assign is_byte   = pkt.valid && pkt.ready && (pkt.command == CMD_BYTE);
    assign is_set    = pkt.valid && pkt.ready && (pkt.command == CMD_ACTIVE);

    // a first byte restarts parsing before the byte is processed
    assign phase_cur = pkt.first_byte ? PH_COUNT : phase_reg;
    assign pos_cur   = pkt.first_byte ? 16'd0 : pos_reg;
    assign hcnt_cur  = pkt.first_byte ? 3'd0 : hcnt_reg;
    assign seen_cur  = pkt.first_byte ? 32'd0 : seen_reg;
    assign we_cur    = pkt.first_byte ? 1'b0 : we_reg;

    assign pos_inc   = {1'b0, pos_cur} + 17'd1;
    assign last_byte = pos_inc >= {1'b0, pkt.packet_length};
    assign hdr_stop  = (seen_cur >= total_reg) ||
                       (({1'b0, pos_cur} + 17'd8) > {1'b0, pkt.packet_length});
    assign rec_size  = {pkt.packet_byte, hdr_reg[55:32]};
    assign rec_slot  = hdr_reg[23:0] - 24'd1;
    assign fits      = (34'(pos_inc) + 34'(rec_size)) <= 34'(pkt.packet_length);
    assign size_zero = rec_size == 32'd0;
    assign acc_rec   = (hdr_reg[23:0] != 24'd0) &&
                       (rec_slot < 24'(entity_limit)) &&
                       (32'(rec_slot) < 32'(SLOT_COUNT)) &&
                       (33'(rec_size) <= 33'(DATA_BYTES)) &&
                       act_reg;
    assign data_end  = rem_reg == 16'd1;

    // slot lookup is issued once the id is complete
    assign id_read   = is_byte && (phase_cur == PH_HDR) && (hcnt_cur == ID_LAST);
    assign rd_slot   = {pkt.packet_byte, hdr_reg[15:0]} - 24'd1;
    assign sidx_ext  = {{AW{1'b0}}, pkt.slot_index};

    assign mem_ctl.rd_en  = id_read;
    assign mem_ctl.wr_en  = is_set && (32'(pkt.slot_index) < 32'(SLOT_COUNT));
    assign mem_ctl.wr_val = pkt.active_value;
    assign mem_raddr      = rd_slot[AW-1:0];
    assign mem_waddr      = sidx_ext[AW-1:0];

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_byte)
        begin
            phase_next = phase_cur;
            case (phase_cur)
                PH_COUNT:
                begin
                    if (pos_cur[1:0] == COUNT_LAST)
                        phase_next = PH_HDR;
                end
                PH_HDR:
                begin
                    if ((hcnt_cur == 3'd0) && hdr_stop)
                        phase_next = PH_SKIP;
                    else if (hcnt_cur == HDR_LAST)
                    begin
                        if (!fits)
                            phase_next = PH_SKIP;
                        else if (!size_zero)
                            phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (data_end)
                        phase_next = PH_HDR;
                end
                PH_SKIP:
                begin
                    phase_next = PH_SKIP;
                end
                default:
                begin
                    phase_next = PH_COUNT;
                end
            endcase
            if (last_byte)
                phase_next = PH_COUNT;
        end
    end

    // datapath and results
    always_comb
    begin
        pos_next   = pos_reg;
        total_next = total_reg;
        seen_next  = seen_reg;
        hdr_next   = hdr_reg;
        hcnt_next  = hcnt_reg;
        slot_next  = slot_reg;
        size_next  = size_reg;
        rem_next   = rem_reg;
        off_next   = off_reg;
        we_next    = we_reg;
        a_v        = 1'b0;
        b_v        = 1'b0;
        c_v        = 1'b0;
        res_a      = '0;
        res_b      = '0;
        res_c      = '0;

        if (is_byte)
        begin
            seen_next = seen_cur;
            hcnt_next = hcnt_cur;
            we_next   = we_cur;
            pos_next  = pos_inc[15:0];

            case (phase_cur)
                PH_COUNT:
                begin
                    total_next[8*pos_cur[1:0] +: 8] = pkt.packet_byte;
                    hcnt_next = 3'd0;
                end
                PH_HDR:
                begin
                    if ((hcnt_cur != 3'd0) || !hdr_stop)
                    begin
                        if (hcnt_cur != HDR_LAST)
                        begin
                            hdr_next[8*hcnt_cur +: 8] = pkt.packet_byte;
                            hcnt_next = hcnt_cur + 3'd1;
                        end
                        else if (fits)
                        begin
                            hcnt_next = 3'd0;
                            seen_next = seen_cur + 32'd1;
                            if (size_zero)
                            begin
                                b_v = acc_rec;
                                res_b.kind        = KIND_SIZE;
                                res_b.entity_slot = rec_slot[11:0];
                            end
                            else
                            begin
                                slot_next = rec_slot[11:0];
                                size_next = rec_size[8:0];
                                rem_next  = rec_size[15:0];
                                off_next  = 8'd0;
                                we_next   = acc_rec;
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    a_v = we_cur;
                    res_a.kind        = KIND_WRITE;
                    res_a.entity_slot = slot_reg;
                    res_a.byte_offset = off_reg;
                    res_a.data_value  = pkt.packet_byte;
                    rem_next = rem_reg - 16'd1;
                    off_next = off_reg + 8'd1;
                    if (data_end)
                    begin
                        b_v = we_cur;
                        res_b.kind        = KIND_SIZE;
                        res_b.entity_slot = slot_reg;
                        res_b.record_size = size_reg;
                        we_next   = 1'b0;
                        hcnt_next = 3'd0;
                    end
                end
                PH_SKIP:
                begin
                    hcnt_next = hcnt_cur;
                end
                default:
                begin
                    hcnt_next = 3'd0;
                end
            endcase

            if (last_byte)
            begin
                c_v             = 1'b1;
                res_c.kind      = KIND_DONE;
                res_c.packet_ok = pkt.packet_length >= 16'd4;
                pos_next        = 16'd0;
                seen_next       = 32'd0;
                hcnt_next       = 3'd0;
                we_next         = 1'b0;
            end
        end

        res_a.last = !b_v && !c_v;
        res_b.last = !c_v;
        res_c.last = 1'b1;
    end

    // active bit of the slot under lookup, kept current against later sets
    always_comb
    begin
        rd_pend_next  = id_read;
        lat_slot_next = id_read ? rd_slot : lat_slot_reg;
        act_next      = rd_pend_reg ? mem_rdata : act_reg;
        if (mem_ctl.wr_en && ({12'd0, pkt.slot_index} == lat_slot_reg))
            act_next = pkt.active_value;
    end

    always_comb
    begin
        bundle[0] = a_v ? res_a : (b_v ? res_b : res_c);
        bundle[1] = a_v ? (b_v ? res_b : res_c) : res_c;
        bundle[2] = res_c;
        push_n    = RES_CNT_W'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_COUNT;
            pos_reg     <= '0;
            seen_reg    <= '0;
            hcnt_reg    <= '0;
            we_reg      <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            seen_reg    <= seen_next;
            hcnt_reg    <= hcnt_next;
            we_reg      <= we_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg    <= total_next;
        hdr_reg      <= hdr_next;
        slot_reg     <= slot_next;
        size_reg     <= size_next;
        rem_reg      <= rem_next;
        off_reg      <= off_next;
        lat_slot_reg <= lat_slot_next;
        act_reg      <= act_next;
    end

    `EUPD_ASSERT_IMP(a_lookup_done, is_byte && (phase_cur == PH_HDR) && (hcnt_cur == HDR_LAST),
        !rd_pend_reg, "slot lookup still in flight at record decision")
    `EUPD_ASSERT_IMP(a_data_left, phase_reg == PH_DATA, rem_reg != 16'd0,
        "data phase with no bytes left")

endmodule

// ----- sv/entity_update_packet_deframer.sv -----
// Entity update packet deframer.
// pkt: one request per cycle while pkt.ready is high. command 0 carries one packet byte (first_byte
//   marks a packet start, packet_length is the packet size); command 1 sets
//   the active bit of slot_index and gives no result.
// res: 0 to 3 results per byte request (data write, size update, packet
//   done), the final one of each request flagged by last.
// APB: register 0 at byte address 0 is entity_limit; pready is always high.
// Results are written into the result queue when their request is taken.
// Throughput: one request per cycle while each yields at most one result
//   and res is ready; the result port drains one result per cycle while
//   res.ready is high. pkt.ready drops while the 8-entry result queue
//   has fewer than three free entries.
// Active bits sit in a single-port-write, one-read RAM; the lookup is issued
//   on the third header byte and resolved by the eighth.
// Reset: parse state clears at once, then a sweep clears the active-bit RAM,
//   one slot per cycle (SLOT_COUNT slots, 4096 by default) with pkt.ready
//   low. APB writes are taken during the sweep.
// A stalled res port fills the queue and then back-pressures pkt.
module entity_update_packet_deframer #(
    parameter int SLOT_COUNT = eupd_pkg::SLOT_COUNT_DEF,
    parameter int DATA_BYTES = eupd_pkg::DATA_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    eupd_pkt_if.sink    pkt,
    eupd_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import eupd_pkg::*;

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [LIMIT_W-1:0]                  limit_reg;
    logic [LIMIT_W-1:0]                  limit_next;
    slot_ctl_t                           mem_ctl;
    logic [AW-1:0]                       mem_raddr;
    logic [AW-1:0]                       mem_waddr;
    logic                                mem_rdata;
    logic                                busy;
    logic                                space_ok;
    logic [RES_CNT_W-1:0]                push_n;
    res_t [RES_PER_ITEM-1:0]             bundle;

    assign pready = 1'b1;

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_ENTITY_LIMIT))
            limit_next = pwdata[LIMIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else
            limit_reg <= limit_next;
    end

    assign prdata = (paddr[2] == REG_ENTITY_LIMIT) ? 32'(limit_reg) : 32'd0;

    eupd_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .raddr (mem_raddr),
        .waddr (mem_waddr),
        .rdata (mem_rdata),
        .busy  (busy)
    );

    eupd_parser #(
        .SLOT_COUNT (SLOT_COUNT),
        .DATA_BYTES (DATA_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .pkt          (pkt),
        .entity_limit (limit_reg),
        .busy         (busy),
        .space_ok     (space_ok),
        .mem_ctl      (mem_ctl),
        .mem_raddr    (mem_raddr),
        .mem_waddr    (mem_waddr),
        .mem_rdata    (mem_rdata),
        .push_n       (push_n),
        .bundle       (bundle)
    );

    eupd_res_fifo u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_n   (push_n),
        .bundle   (bundle),
        .space_ok (space_ok),
        .res      (res)
    );

endmodule
